### rtl/cwk_pkg.sv
// Shared types and constants for the CW keyer envelope block.
// No dependencies; imported by the top level and the bench.
package cwk_pkg;

	// Keyer sequence phase, as shown on the result word
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DOT   = 2'd1,
		PH_DASH  = 2'd2,
		PH_SPACE = 2'd3
	} phase_t;

	// Register indexes; byte address is 4 * index
	localparam logic REG_KEYER_ENABLE = 1'b0;
	localparam logic REG_WPM          = 1'b1;

	localparam int DOT_BITS  = 11;
	localparam int DASH_BITS = 12;
	localparam int WPM_BITS  = 6;

	localparam logic [WPM_BITS-1:0]  WPM_RESET = 6'd20;
	localparam logic [DOT_BITS-1:0]  DOT_RESET = 11'd60;
	localparam logic [DASH_BITS-1:0] DASH_RESET = 12'd180;

	// Ramp coefficient 0.007 in Q0.16
	localparam logic [8:0] RAMP_COEF = 9'd459;

	// Dot length in ms = 1200 / wpm, zero speed treated as one
	function automatic logic [DOT_BITS-1:0] dot_length_lookup(input logic [WPM_BITS-1:0] wpm);
		logic [DOT_BITS-1:0] len;
		case (wpm)
			6'd0:  len = 11'd1200;
			6'd1:  len = 11'd1200;
			6'd2:  len = 11'd600;
			6'd3:  len = 11'd400;
			6'd4:  len = 11'd300;
			6'd5:  len = 11'd240;
			6'd6:  len = 11'd200;
			6'd7:  len = 11'd171;
			6'd8:  len = 11'd150;
			6'd9:  len = 11'd133;
			6'd10: len = 11'd120;
			6'd11: len = 11'd109;
			6'd12: len = 11'd100;
			6'd13: len = 11'd92;
			6'd14: len = 11'd85;
			6'd15: len = 11'd80;
			6'd16: len = 11'd75;
			6'd17: len = 11'd70;
			6'd18: len = 11'd66;
			6'd19: len = 11'd63;
			6'd20: len = 11'd60;
			6'd21: len = 11'd57;
			6'd22: len = 11'd54;
			6'd23: len = 11'd52;
			6'd24: len = 11'd50;
			6'd25: len = 11'd48;
			6'd26: len = 11'd46;
			6'd27: len = 11'd44;
			6'd28: len = 11'd42;
			6'd29: len = 11'd41;
			6'd30: len = 11'd40;
			6'd31: len = 11'd38;
			6'd32: len = 11'd37;
			6'd33: len = 11'd36;
			6'd34: len = 11'd35;
			6'd35: len = 11'd34;
			6'd36: len = 11'd33;
			6'd37: len = 11'd32;
			6'd38: len = 11'd31;
			6'd39: len = 11'd30;
			6'd40: len = 11'd30;
			6'd41: len = 11'd29;
			6'd42: len = 11'd28;
			6'd43: len = 11'd27;
			6'd44: len = 11'd27;
			6'd45: len = 11'd26;
			6'd46: len = 11'd26;
			6'd47: len = 11'd25;
			6'd48: len = 11'd25;
			6'd49: len = 11'd24;
			6'd50: len = 11'd24;
			6'd51: len = 11'd23;
			6'd52: len = 11'd23;
			6'd53: len = 11'd22;
			6'd54: len = 11'd22;
			6'd55: len = 11'd21;
			6'd56: len = 11'd21;
			6'd57: len = 11'd21;
			6'd58: len = 11'd20;
			6'd59: len = 11'd20;
			6'd60: len = 11'd20;
			6'd61: len = 11'd19;
			6'd62: len = 11'd19;
			6'd63: len = 11'd19;
			default: len = DOT_RESET;
		endcase
		return len;
	endfunction

endpackage

### rtl/cwk_sample_if.sv
// Input channel: one word per audio sample (keys, target level, ms time).
// Depends on nothing; LEVEL_BITS must match the top level.
interface cwk_sample_if #(parameter int LEVEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic                  dot_key;
	logic                  dash_key;
	logic                  serial_key;
	logic                  ptt_key;
	logic [LEVEL_BITS-1:0] target_level;
	logic [31:0]           time_ms;

	modport source (
		output valid, dot_key, dash_key, serial_key, ptt_key, target_level, time_ms,
		input  ready
	);
	modport sink (
		input  valid, dot_key, dash_key, serial_key, ptt_key, target_level, time_ms,
		output ready
	);
endinterface

### rtl/cwk_result_if.sv
// Result channel: envelope amplitude, keyer phase and timeout reload flag.
// Depends on nothing; LEVEL_BITS must match the top level.
interface cwk_result_if #(parameter int LEVEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] envelope;
	logic [1:0]            keyer_phase;
	logic                  timeout_reload;

	modport source (
		output valid, envelope, keyer_phase, timeout_reload,
		input  ready
	);
	modport sink (
		input  valid, envelope, keyer_phase, timeout_reload,
		output ready
	);
endinterface

### rtl/cw_keyer_envelope.sv
// CW keyer with shaped carrier envelope: keyer sequencer plus ramp generator.
// Depends on cwk_pkg, cwk_sample_if and cwk_result_if.
//
// Usage:
//   sample : valid/ready channel, one word per audio sample carrying the dot,
//            dash, serial and PTT keys, the target level and the ms time.
//   result : valid/ready channel, one word per sample word: envelope,
//            keyer phase and the transmit hold timeout reload flag.
//   APB    : keyer_enable at 0x0, words_per_minute at 0x4 (dot length is
//            looked up when the speed is written). Write only while idle.
// A word accepted on sample passes the input register, then the result register.
// Throughput: one word per cycle unless result stalls. Keyer state and envelope
// level feed back through a single register stage, so the next word uses them at once.
// The input register and the result register are separate: a new word is
// taken while a finished result waits. If result stalls, the input register
// fills and sample.ready drops until result.ready returns.
// Reset (arst_n low): phase idle, symbol start 0, level 0, keyer enabled,
// 20 wpm (60 ms dot). Both channel registers come up empty.
module cw_keyer_envelope
	import cwk_pkg::*;
#(
	parameter int LEVEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	cwk_sample_if.sink          sample,
	cwk_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int PROD_BITS = LEVEL_BITS + 9;
	localparam int STEP_BITS = PROD_BITS - 16;

	// Configuration registers
	logic                 keyer_en_q;
	logic [WPM_BITS-1:0]  wpm_q;
	logic [DOT_BITS-1:0]  dot_len_q;
	logic [DASH_BITS-1:0] dash_len_q;

	// Keyer and envelope state
	phase_t               phase_q;
	logic [31:0]          start_q;
	logic [LEVEL_BITS-1:0] level_q;

	// Input register
	logic                  valid_s1;
	logic                  dot_s1;
	logic                  dash_s1;
	logic                  serial_s1;
	logic                  ptt_s1;
	logic [LEVEL_BITS-1:0] target_s1;
	logic [STEP_BITS-1:0]  step_s1;
	logic [31:0]           time_s1;

	// Result register
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] envelope_q;
	phase_t                out_phase_q;
	logic                  reload_q;

	logic                  wr_en;
	logic                  advance;
	logic                  fire;
	logic [PROD_BITS-1:0]  prod;
	logic [DOT_BITS-1:0]   new_dot;

	// APB access
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign new_dot = dot_length_lookup(pwdata[WPM_BITS-1:0]);

	always_comb begin
		case (paddr[2])
			REG_KEYER_ENABLE: prdata = {31'd0, keyer_en_q};
			REG_WPM:          prdata = {{(32-WPM_BITS){1'b0}}, wpm_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyer_en_q <= 1'b1;
			wpm_q      <= WPM_RESET;
			dot_len_q  <= DOT_RESET;
			dash_len_q <= DASH_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_KEYER_ENABLE: keyer_en_q <= pwdata[0];
				REG_WPM: begin
					wpm_q      <= pwdata[WPM_BITS-1:0];
					dot_len_q  <= new_dot;
					// dash = 3 dots
					dash_len_q <= {1'b0, new_dot} + {new_dot, 1'b0};
				end
				default: ;
			endcase
		end
	end

	// Handshake: the stage advances whenever the result register frees up
	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	// Ramp step computed ahead of the input register
	assign prod = PROD_BITS'(sample.target_level) * PROD_BITS'(RAMP_COEF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			dot_s1    <= sample.dot_key;
			dash_s1   <= sample.dash_key;
			serial_s1 <= sample.serial_key;
			ptt_s1    <= sample.ptt_key;
			target_s1 <= sample.target_level;
			step_s1   <= prod[PROD_BITS-1:16];
			time_s1   <= sample.time_ms;
		end
	end

	// Symbol end times, from the stored start or from the current time
	logic [31:0] end_dot_old, end_dash_old, end_dot_now, end_dash_now;
	assign end_dot_old  = start_q + 32'(dot_len_q);
	assign end_dash_old = start_q + 32'(dash_len_q);
	assign end_dot_now  = time_s1 + 32'(dot_len_q);
	assign end_dash_now = time_s1 + 32'(dash_len_q);

	// Keyer sequencer: decides phase, start time, ramp direction and reload
	phase_t      ph_nxt;
	logic        start_now;
	logic        ramp_up;
	logic        reload;
	logic        done;
	logic [31:0] end_sel;

	always_comb begin
		ph_nxt    = phase_q;
		start_now = 1'b0;
		ramp_up   = 1'b0;
		reload    = 1'b0;
		done      = 1'b0;
		end_sel   = end_dot_old;
		if (!keyer_en_q) begin
			ramp_up = serial_s1 || ptt_s1 || dot_s1 || dash_s1;
		end else if (serial_s1) begin
			ramp_up = 1'b1;
		end else begin
			// dot
			if (ph_nxt == PH_IDLE && dot_s1) begin
				ph_nxt    = PH_DOT;
				start_now = 1'b1;
			end
			if (ph_nxt == PH_DOT) begin
				end_sel = start_now ? end_dot_now : end_dot_old;
				if (end_sel > time_s1) begin
					ramp_up = 1'b1;
					reload  = 1'b1;
					done    = 1'b1;
				end else if (end_sel < time_s1) begin
					ph_nxt    = PH_SPACE;
					start_now = 1'b1;
				end
			end
			// dash
			if (!done && ph_nxt == PH_IDLE && dash_s1) begin
				ph_nxt    = PH_DASH;
				start_now = 1'b1;
			end
			if (!done && ph_nxt == PH_DASH) begin
				end_sel = start_now ? end_dash_now : end_dash_old;
				if (end_sel > time_s1) begin
					ramp_up = 1'b1;
					reload  = 1'b1;
					done    = 1'b1;
				end else if (end_sel < time_s1) begin
					ph_nxt    = PH_SPACE;
					start_now = 1'b1;
				end
			end
			// inter-symbol space; exact end time keeps the phase
			if (!done && ph_nxt == PH_SPACE) begin
				end_sel = start_now ? end_dot_now : end_dot_old;
				if (end_sel > time_s1) begin
					reload = 1'b1;
				end else if (end_sel < time_s1) begin
					ph_nxt = PH_IDLE;
				end
			end
		end
	end

	// Envelope ramp: rise wraps at the level width, then clamps to target
	logic [LEVEL_BITS-1:0] step_ext, lvl_up, lvl_rise, lvl_fall, lvl_nxt;
	assign step_ext = LEVEL_BITS'(step_s1);
	assign lvl_up   = (level_q < target_s1) ? LEVEL_BITS'(level_q + step_ext) : level_q;
	assign lvl_rise = (lvl_up > target_s1) ? target_s1 : lvl_up;
	assign lvl_fall = (step_ext >= level_q) ? '0 : level_q - step_ext;
	assign lvl_nxt  = ramp_up ? lvl_rise : lvl_fall;

	// State update as the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= 32'd0;
			level_q <= '0;
		end else if (fire) begin
			phase_q <= ph_nxt;
			level_q <= lvl_nxt;
			if (start_now) begin
				start_q <= time_s1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			envelope_q  <= lvl_nxt;
			out_phase_q <= ph_nxt;
			reload_q    <= reload;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.envelope       = envelope_q;
	assign result.keyer_phase    = out_phase_q;
	assign result.timeout_reload = reload_q;

	// Checks
	a_reload_needs_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.timeout_reload |-> result.keyer_phase != PH_IDLE)
		else $error("timeout reload flagged with keyer idle");

	a_bypass_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !keyer_en_q |=> phase_q == $past(phase_q) && start_q == $past(start_q))
		else $error("keyer state moved while keyer disabled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> sample.ready)
		else $error("sample stalled with empty result register");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> envelope_q == level_q && out_phase_q == phase_q)
		else $error("result word differs from updated state");

endmodule

### bench/cw_keyer_envelope_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cw_keyer_envelope: a directed table, then random keying phases.
// Depends on cwk_pkg, cwk_sample_if, cwk_result_if and the cw_keyer_envelope RTL.
module cw_keyer_envelope_tb
	import cwk_pkg::*;
();

	typedef struct packed {
		logic        dot;
		logic        dash;
		logic        serial;
		logic        ptt;
		logic [15:0] target;
		logic [31:0] ms;
	} sample_t;

	typedef struct packed {
		logic [15:0] env;
		phase_t      ph;
		logic        reload;
	} result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic       reg_idx;
		logic [5:0] reg_val;
		sample_t    smp;
		logic       typed;
		result_t    want;
	} row_t;

	localparam int          NUM_ROWS     = 28;
	localparam int          NUM_PHASES   = 8;
	localparam int          PHASE_ITEMS  = 100;
	localparam int          IDLE_PCT     = 31;
	localparam int          STALL_CYCLES = 80;
	localparam int          RAMP_Q16     = 459;
	localparam logic [15:0] FULL         = 16'hFFFF;
	localparam sample_t     NO_SAMPLE    = '0;
	localparam result_t     NO_CHECK     = '{16'd0, PH_IDLE, 1'b0};

	// per-phase register settings for the random part
	localparam logic [5:0] WPM_PLAN [NUM_PHASES] = '{6'd60, 6'd1, 6'd20, 6'd0,
		6'd63, 6'd20, 6'd13, 6'd20};
	localparam bit EN_PLAN [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cwk_sample_if #(.LEVEL_BITS(16)) sample_ch ();
	cwk_result_if #(.LEVEL_BITS(16)) result_ch ();

	cw_keyer_envelope #(.LEVEL_BITS(16)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// keyer state as the bench sees it
	logic        cfg_en    = 1'b1;
	logic [10:0] dot_len   = 11'd60;
	phase_t      key_phase = PH_IDLE;
	logic [31:0] sym_start = 32'd0;
	logic [15:0] env_level = 16'd0;

	result_t     envelopes_due [$];
	int          fail_count = 0;
	logic [31:0] now_ms     = 32'd0;
	bit          calm       = 1'b0;
	bit          stall_req  = 1'b0;

	// directed words; the expected word is typed in only where it is obvious
	row_t dir_rows [NUM_ROWS] = '{
		// after reset: idle, nothing to ramp
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd0}, 1,
			'{16'd0, PH_IDLE, 1'b0}},
		// dot starts, first full-scale step
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 0, 0, 0, FULL, 32'd100}, 1,
			'{16'd458, PH_DOT, 1'b1}},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 0, 0, 0, FULL, 32'd130}, 0, NO_CHECK},
		// time equal to dot end: level falls, phase held
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd160}, 0, NO_CHECK},
		// dot over, space begins
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd161}, 0, NO_CHECK},
		// space at its exact end
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, FULL, 32'd221}, 0, NO_CHECK},
		// space over; PTT means nothing with the keyer on
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 1, FULL, 32'd222}, 0, NO_CHECK},
		// dash starts with a target too small to move the level
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, 16'd100, 32'd223}, 1,
			'{16'd0, PH_DASH, 1'b1}},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, FULL, 32'd300}, 0, NO_CHECK},
		// serial key overrides, level clamps down to the target
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 1, 0, 16'd200, 32'd300}, 1,
			'{16'd200, PH_DASH, 1'b0}},
		// dash end and space end, time at its maximum
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 1, 0, 0, FULL, 32'hFFFF_FFFF}, 0, NO_CHECK},
		// symbol end wraps past zero
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 0, 0, 0, FULL, 32'hFFFF_FFF0}, 0, NO_CHECK},
		// both paddles: dot wins
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 1, 0, 0, FULL, 32'd5}, 0, NO_CHECK},
		// rising toward a zero target clamps at once
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, 16'd0, 32'd10}, 1,
			'{16'd0, PH_DOT, 1'b1}},
		// keyer off: any key raises, phase frozen
		'{ROW_WRITE, REG_KEYER_ENABLE, 6'd0, NO_SAMPLE, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 1, FULL, 32'd20}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{1, 0, 0, 0, FULL, 32'd20}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd20}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, 16'd0, 32'd20}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 1, 0, FULL, 32'd20}, 0, NO_CHECK},
		// zero speed acts as one wpm
		'{ROW_WRITE, REG_WPM, 6'd0, NO_SAMPLE, 0, NO_CHECK},
		'{ROW_WRITE, REG_KEYER_ENABLE, 6'd1, NO_SAMPLE, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd20}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd1205}, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 0, 0, 0, FULL, 32'd1206}, 0, NO_CHECK},
		// top speed
		'{ROW_WRITE, REG_WPM, 6'd63, NO_SAMPLE, 0, NO_CHECK},
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, FULL, 32'd1300}, 0, NO_CHECK},
		// time steps backwards as a dash starts
		'{ROW_SAMPLE, REG_KEYER_ENABLE, 6'd0, '{0, 1, 0, 0, FULL, 32'd0}, 0, NO_CHECK}
	};

	// ramp increment for a given target, from the Q0.16 coefficient
	function automatic logic [8:0] ramp_step(input logic [15:0] tgt);
		logic [24:0] prod;
		prod = 25'(tgt) * 25'(RAMP_Q16);
		return prod[24:16];
	endfunction

	// rise toward target; the add wraps at 16 bits
	function automatic void ramp_up(input logic [15:0] tgt);
		if (env_level < tgt) begin
			env_level = env_level + 16'(ramp_step(tgt));
		end
		if (env_level > tgt) begin
			env_level = tgt;
		end
	endfunction

	function automatic void ramp_down(input logic [15:0] tgt);
		logic [15:0] step;
		step = 16'(ramp_step(tgt));
		if (env_level != 16'd0) begin
			env_level = (step >= env_level) ? 16'd0 : env_level - step;
		end
	endfunction

	// envelope, phase and reload flag after one sample word
	function automatic result_t predict_envelope(input sample_t s);
		result_t     r;
		logic        done;
		logic [31:0] stop_ms;
		r.reload = 1'b0;
		done = 1'b0;
		if (!cfg_en || s.serial) begin
			if (s.dot || s.dash || s.serial || s.ptt) begin
				ramp_up(s.target);
			end else begin
				ramp_down(s.target);
			end
		end else begin
			if (key_phase == PH_IDLE && s.dot) begin
				sym_start = s.ms;
				key_phase = PH_DOT;
			end
			if (key_phase == PH_DOT) begin
				stop_ms = sym_start + 32'(dot_len);
				if (stop_ms > s.ms) begin
					ramp_up(s.target);
					r.reload = 1'b1;
					done = 1'b1;
				end else if (stop_ms < s.ms) begin
					sym_start = s.ms;
					key_phase = PH_SPACE;
				end
			end
			if (!done && key_phase == PH_IDLE && s.dash) begin
				sym_start = s.ms;
				key_phase = PH_DASH;
			end
			if (!done && key_phase == PH_DASH) begin
				stop_ms = sym_start + 32'(dot_len) * 3;
				if (stop_ms > s.ms) begin
					ramp_up(s.target);
					r.reload = 1'b1;
					done = 1'b1;
				end else if (stop_ms < s.ms) begin
					sym_start = s.ms;
					key_phase = PH_SPACE;
				end
			end
			if (!done && key_phase == PH_SPACE) begin
				stop_ms = sym_start + 32'(dot_len);
				if (stop_ms > s.ms) begin
					ramp_down(s.target);
					r.reload = 1'b1;
					done = 1'b1;
				end else if (stop_ms < s.ms) begin
					key_phase = PH_IDLE;
				end
			end
			if (!done) begin
				ramp_down(s.target);
			end
		end
		r.env = env_level;
		r.ph  = key_phase;
		return r;
	endfunction

	// offer one word, with random gaps unless calm; called and returns at a falling edge
	task automatic send_sample(input sample_t s, input logic typed, input result_t want);
		result_t due;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.dot_key      <= s.dot;
		sample_ch.dash_key     <= s.dash;
		sample_ch.serial_key   <= s.serial;
		sample_ch.ptt_key      <= s.ptt;
		sample_ch.target_level <= s.target;
		sample_ch.time_ms      <= s.ms;
		sample_ch.valid        <= 1'b1;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		due = predict_envelope(s);
		envelopes_due.push_back(typed ? want : due);
		@(negedge clk);
	endtask

	// stop sending and wait for every outstanding word
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (envelopes_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write followed by a read-back; keeps the bench's copy of the config
	task automatic reg_write(input logic idx, input logic [31:0] val);
		logic [31:0] readback;
		logic [31:0] stored;
		stored = (idx == REG_KEYER_ENABLE) ? {31'd0, val[0]} : {26'd0, val[5:0]};
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== stored) begin
			$display("%0t: register %0d read back exp %0d got %0d",
				$time, idx, stored, readback);
			fail_count++;
		end
		if (idx == REG_KEYER_ENABLE) begin
			cfg_en = val[0];
		end else begin
			dot_len = 11'(1200 / ((val[5:0] == 6'd0) ? 1 : int'(val[5:0])));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random back-pressure unless calm, one long hold on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (envelopes_due.size() == 0) begin
				$display("%0t: result word with none due, envelope %0d",
					$time, result_ch.envelope);
				fail_count++;
			end else begin
				want = envelopes_due.pop_front();
				if (result_ch.envelope !== want.env) begin
					$display("%0t: envelope exp %0d got %0d",
						$time, want.env, result_ch.envelope);
					fail_count++;
				end
				if (result_ch.keyer_phase !== want.ph) begin
					$display("%0t: keyer_phase exp %0d got %0d",
						$time, want.ph, result_ch.keyer_phase);
					fail_count++;
				end
				if (result_ch.timeout_reload !== want.reload) begin
					$display("%0t: timeout_reload exp %0d got %0d",
						$time, want.reload, result_ch.timeout_reload);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		sample_t     s;
		int          p;
		int          n;
		int          seg_len;
		int          pick;
		logic        seg_dot;
		logic        seg_dash;
		logic        seg_serial;
		logic        seg_noise;
		logic [15:0] seg_tgt;
		logic [5:0]  wpm;
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.dot_key      = 1'b0;
		sample_ch.dash_key     = 1'b0;
		sample_ch.serial_key   = 1'b0;
		sample_ch.ptt_key      = 1'b0;
		sample_ch.target_level = '0;
		sample_ch.time_ms      = '0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				drain_results();
				reg_write(dir_rows[i].reg_idx, 32'(dir_rows[i].reg_val));
			end else begin
				send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases, one register setting each
		for (p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			wpm = (p == 5) ? 6'($urandom_range(0, 63)) : WPM_PLAN[p];
			reg_write(REG_KEYER_ENABLE, 32'(EN_PLAN[p]));
			reg_write(REG_WPM, 32'(wpm));
			calm = (p == 3);
			if (p == 5) begin
				stall_req = 1'b1;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				// a segment holds one key pattern; picks from 88 up are noise
				pick       = $urandom_range(0, 99);
				seg_dot    = (pick < 30) || (pick >= 55 && pick < 65);
				seg_dash   = (pick >= 30 && pick < 65);
				seg_serial = (pick >= 80 && pick < 88);
				seg_noise  = (pick >= 88);
				seg_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 170)
					: $urandom_range(1, 40);
				// the phase ends at its word count
				if (seg_len > PHASE_ITEMS - n) begin
					seg_len = PHASE_ITEMS - n;
				end
				pick       = $urandom_range(0, 7);
				seg_tgt    = (pick < 2) ? FULL
					: (pick == 2) ? 16'($urandom_range(0, 200)) : 16'($urandom());
				repeat (seg_len) begin
					if ($urandom_range(0, 9) == 0) begin
						seg_tgt = 16'($urandom());
					end
					pick = $urandom_range(0, 39);
					if (pick == 0) begin
						now_ms = $urandom();
					end else if (pick == 1) begin
						now_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
					end else begin
						now_ms = now_ms + $urandom_range(0, dot_len / 6 + 1);
					end
					s.dot    = seg_noise ? 1'($urandom_range(0, 1)) : seg_dot;
					s.dash   = seg_noise ? 1'($urandom_range(0, 1)) : seg_dash;
					s.serial = seg_noise ? 1'($urandom_range(0, 1)) : seg_serial;
					s.ptt    = ($urandom_range(0, 7) == 0);
					s.target = seg_tgt;
					s.ms     = now_ms;
					send_sample(s, 1'b0, NO_CHECK);
					n++;
				end
			end
		end
		drain_results();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
